/* design/icsp_pkg.sv */
// Shared types, constants and a helper function for the IP-classifier stride prefetcher.
// No dependencies; the front end, back end and top-level files refer to this package by scoped names.
`timescale 1ns / 1ps

package icsp_pkg;

    // Table geometry and address split.
    localparam int INDEX_BITS  = 10;
    localparam int TAG_BITS    = 6;
    localparam int BLOCK_SHIFT = 6;
    localparam int PAGE_SHIFT  = 12;
    localparam int TABLE_DEPTH = 1 << INDEX_BITS;

    // Field widths.
    localparam int ADDR_W   = 64;
    localparam int META_W   = 13;
    localparam int CLASS_W  = 4;
    localparam int STRIDE_W = 7;
    localparam int DEG_W    = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE = 2'd1;

    // Degree limits.
    localparam logic [DEG_W-1:0] MAX_DEGREE = 5'd16;
    localparam logic [DEG_W-1:0] GS_DEGREE  = 5'd4;

    // Class codes carried in the metadata.
    localparam logic [CLASS_W-1:0] CLS_GS = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_CS = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_NL = 4'd4;

    // Metadata bit positions.
    localparam int META_SIGN_BIT  = 6;
    localparam int META_CLASS_LSB = 8;
    localparam int META_SPEC_BIT  = 12;

    // Input queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic                  valid;
        logic [TAG_BITS-1:0]   tag;
        logic [CLASS_W-1:0]    cls;
        logic [STRIDE_W-1:0]   stride;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [ADDR_W-1:0]     addr;
        logic [META_W-1:0]     meta;
        logic                  fill;
        logic [TAG_BITS-1:0]   tag;
        logic [INDEX_BITS-1:0] idx;
        logic [CLASS_W-1:0]    new_class;
        logic [STRIDE_W-1:0]   new_stride;
    } t_item;

    typedef struct packed {
        logic              pf_valid;
        logic [ADDR_W-1:0] pf_addr;
        logic [META_W-1:0] meta_out;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic             single_core;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_NL,
        KIND_STRIDE
    } t_kind;

    // Sign-magnitude stride of the metadata to two's complement.
    function automatic logic [STRIDE_W-1:0] encode_stride(input logic [META_W-1:0] meta);
        logic [STRIDE_W-1:0] mag;
        mag = {1'b0, meta[STRIDE_W-2:0]};
        if (meta[META_SIGN_BIT]) begin
            return STRIDE_W'(-mag);
        end
        return mag;
    endfunction

endpackage

/* design/icsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module icsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/icsp_front.sv */
// Front end: accepts cache accesses, splits the instruction pointer and metadata,
// and holds them in a short queue for the back end. Depends on icsp_pkg.
`timescale 1ns / 1ps

module icsp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [icsp_pkg::ADDR_W-1:0]         i_access_addr,
    input  logic [icsp_pkg::ADDR_W-1:0]         i_instr_ptr,
    input  logic                                i_is_prefetch_fill,
    input  logic [icsp_pkg::META_W-1:0]         i_meta_in,
    input  logic                                i_hold,
    output logic                                o_head_valid,
    output icsp_pkg::t_item                     o_head,
    input  logic                                i_head_pop
);

    icsp_pkg::t_item                 r_q [icsp_pkg::QDEPTH];
    logic [icsp_pkg::QPTR_W-1:0]     r_wp;
    logic [icsp_pkg::QPTR_W-1:0]     r_rp;
    logic [icsp_pkg::QPTR_W:0]       r_cnt;
    icsp_pkg::t_item                 dec;
    logic                            wr_ok;
    logic                            rd_ok;

    always_comb begin
        dec.addr       = i_access_addr;
        dec.meta       = i_meta_in;
        dec.fill       = i_is_prefetch_fill;
        dec.tag        = i_instr_ptr[icsp_pkg::INDEX_BITS +: icsp_pkg::TAG_BITS];
        dec.idx        = i_instr_ptr[icsp_pkg::INDEX_BITS-1:0];
        dec.new_class  = i_meta_in[icsp_pkg::META_CLASS_LSB +: icsp_pkg::CLASS_W];
        dec.new_stride = icsp_pkg::encode_stride(i_meta_in);
    end

    // The queue stays closed while the table is being cleared.
    assign o_full       = (r_cnt == (icsp_pkg::QPTR_W+1)'(icsp_pkg::QDEPTH)) || i_hold;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];
    assign wr_ok        = i_push && !o_full;
    assign rd_ok        = i_head_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (icsp_pkg::QPTR_W+1)'(wr_ok) - (icsp_pkg::QPTR_W+1)'(rd_ok);
        end
    end

endmodule

/* design/icsp_back.sv */
// Back end: table lookup and update, class decision and prefetch address generation
// into an output register. Depends on icsp_pkg and icsp_ram.
`timescale 1ns / 1ps

module icsp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  icsp_pkg::t_cfg      i_cfg,
    input  logic                i_item_valid,
    input  icsp_pkg::t_item     i_item,
    output logic                o_item_pop,
    output logic                o_clearing,
    output logic                o_res_valid,
    output icsp_pkg::t_result   o_res,
    input  logic                i_res_pop
);

    localparam int AW = icsp_pkg::ADDR_W;

    icsp_pkg::t_state                  r_state;
    icsp_pkg::t_state                  n_state;
    logic [icsp_pkg::INDEX_BITS-1:0]   r_clr_idx;
    icsp_pkg::t_item                   r_item;
    logic                              r_spec;
    icsp_pkg::t_kind                   r_kind;
    logic [icsp_pkg::DEG_W-1:0]        r_deg;
    logic [icsp_pkg::DEG_W-1:0]        r_k;
    logic [AW-1:0]                     r_stride64;
    logic [AW-1:0]                     r_acc;
    logic [AW-1:0]                     r_acc2;
    logic                              r_out_valid;
    icsp_pkg::t_result                 r_out;

    logic                              wr_en;
    logic [icsp_pkg::INDEX_BITS-1:0]   wr_addr;
    logic [icsp_pkg::ENTRY_W-1:0]      wr_data;
    logic                              rd_en;
    logic [icsp_pkg::ENTRY_W-1:0]      rd_data;

    icsp_pkg::t_entry                  ent;
    icsp_pkg::t_entry                  upd;
    logic                              hit;
    logic                              spec_eff;
    logic [icsp_pkg::DEG_W-1:0]        deg_eff;
    icsp_pkg::t_kind                   kind_eff;
    logic [AW-1:0]                     stride_sx;
    logic [AW-1:0]                     line;

    logic [AW-1:0]                     cur_pf;
    logic [AW-1:0]                     nxt_pf;
    logic                              cross_cur;
    logic                              cross_nxt;
    icsp_pkg::t_result                 res;
    logic                              slot_free;
    logic                              emit;
    logic                              done;
    logic                              take;

    icsp_ram #(
        .WIDTH (icsp_pkg::ENTRY_W),
        .DEPTH (icsp_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_item.idx),
        .o_rd_data (rd_data)
    );

    // Lookup result and table update of the item under evaluation.
    always_comb begin
        ent = icsp_pkg::t_entry'(rd_data);
        hit = (ent.tag == r_item.tag);
        upd = ent;
        if (!hit) begin
            if (!ent.valid) begin
                upd.tag    = r_item.tag;
                upd.cls    = r_item.new_class;
                upd.stride = r_item.new_stride;
            end else begin
                upd.valid = 1'b0;
            end
        end else begin
            upd.valid = 1'b1;
            if (r_item.fill) begin
                upd.cls    = r_item.new_class;
                upd.stride = r_item.new_stride;
            end
        end
        spec_eff = (hit && r_item.fill) ? r_item.meta[icsp_pkg::META_SPEC_BIT] : r_spec;

        deg_eff = (i_cfg.degree > icsp_pkg::MAX_DEGREE) ? icsp_pkg::MAX_DEGREE : i_cfg.degree;
        if ((upd.cls == icsp_pkg::CLS_GS) && i_cfg.single_core) begin
            deg_eff = icsp_pkg::GS_DEGREE;
        end

        if (!hit) begin
            kind_eff = icsp_pkg::KIND_NL;
        end else if (upd.stride == '0) begin
            kind_eff = icsp_pkg::KIND_NONE;
        end else if ((upd.cls == icsp_pkg::CLS_GS) || (upd.cls == icsp_pkg::CLS_CS)) begin
            kind_eff = (deg_eff == '0) ? icsp_pkg::KIND_NONE : icsp_pkg::KIND_STRIDE;
        end else if ((upd.cls == icsp_pkg::CLS_NL) && spec_eff) begin
            kind_eff = icsp_pkg::KIND_NL;
        end else begin
            kind_eff = icsp_pkg::KIND_NONE;
        end

        stride_sx = {{(AW-icsp_pkg::STRIDE_W){upd.stride[icsp_pkg::STRIDE_W-1]}}, upd.stride};
    end

    // Result of the current emission cycle.
    always_comb begin
        line      = ((r_item.addr >> icsp_pkg::BLOCK_SHIFT) + AW'(1)) << icsp_pkg::BLOCK_SHIFT;
        cur_pf    = r_acc << icsp_pkg::BLOCK_SHIFT;
        nxt_pf    = r_acc2 << icsp_pkg::BLOCK_SHIFT;
        cross_cur = (cur_pf[AW-1:icsp_pkg::PAGE_SHIFT] != r_item.addr[AW-1:icsp_pkg::PAGE_SHIFT]);
        cross_nxt = (nxt_pf[AW-1:icsp_pkg::PAGE_SHIFT] != r_item.addr[AW-1:icsp_pkg::PAGE_SHIFT]);
        res.meta_out = r_item.meta;
        res.pf_valid = 1'b0;
        res.pf_addr  = '0;
        res.last     = 1'b1;
        case (r_kind)
            icsp_pkg::KIND_NL: begin
                res.pf_valid = 1'b1;
                res.pf_addr  = line;
            end
            icsp_pkg::KIND_STRIDE: begin
                // The first candidate may already leave the page; then nothing is issued.
                if (!cross_cur) begin
                    res.pf_valid = 1'b1;
                    res.pf_addr  = cur_pf;
                    res.last     = (r_k == r_deg) || cross_nxt;
                end
            end
            default: begin
                res.pf_valid = 1'b0;
            end
        endcase
    end

    assign slot_free = !r_out_valid || i_res_pop;

    // Control outputs of the sequencer.
    always_comb begin
        emit    = 1'b0;
        done    = 1'b0;
        take    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_item.idx;
        wr_data = upd;
        case (r_state)
            icsp_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_idx;
                wr_data = '0;
            end
            icsp_pkg::ST_IDLE: begin
                take = i_item_valid;
            end
            icsp_pkg::ST_EVAL: begin
                wr_en = 1'b1;
            end
            icsp_pkg::ST_EMIT: begin
                emit = slot_free;
                done = emit && res.last;
                take = done && i_item_valid;
            end
            default: begin
                take = 1'b0;
            end
        endcase
        rd_en      = take;
        o_item_pop = take;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            icsp_pkg::ST_CLEAR: begin
                if (r_clr_idx == '1) begin
                    n_state = icsp_pkg::ST_IDLE;
                end
            end
            icsp_pkg::ST_IDLE: begin
                if (take) begin
                    n_state = icsp_pkg::ST_EVAL;
                end
            end
            icsp_pkg::ST_EVAL: begin
                n_state = icsp_pkg::ST_EMIT;
            end
            icsp_pkg::ST_EMIT: begin
                if (take) begin
                    n_state = icsp_pkg::ST_EVAL;
                end else if (done) begin
                    n_state = icsp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = icsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= icsp_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_spec      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == icsp_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == icsp_pkg::ST_EVAL) begin
                r_spec <= spec_eff;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
        if (r_state == icsp_pkg::ST_EVAL) begin
            r_kind     <= kind_eff;
            r_deg      <= deg_eff;
            r_k        <= icsp_pkg::DEG_W'(1);
            r_stride64 <= stride_sx;
            r_acc      <= (r_item.addr >> icsp_pkg::BLOCK_SHIFT) + stride_sx;
            r_acc2     <= (r_item.addr >> icsp_pkg::BLOCK_SHIFT) + (stride_sx << 1);
        end else if (emit) begin
            r_acc  <= r_acc2;
            r_acc2 <= r_acc2 + r_stride64;
            r_k    <= r_k + 1'b1;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_clearing  = (r_state == icsp_pkg::ST_CLEAR);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

/* design/ip_class_stride_prefetcher.sv */
// Path: an access word passes the input queue, the table read, the evaluation state and
// the output register; the table sequencer emits an access's result words in turn as the
// output register frees and takes no new access before the last of them is emitted.
// Reset: synchronous; afterwards the table's 1024 entries (2^INDEX_BITS) are cleared one
// entry per cycle while full stays high. Configuration writes are taken at all times.
// Depends on icsp_pkg, icsp_front, icsp_back and icsp_ram.
`timescale 1ns / 1ps

module ip_class_stride_prefetcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Access words.
    input  logic                              push,
    output logic                              full,
    input  logic [icsp_pkg::ADDR_W-1:0]       i_access_addr,
    input  logic [icsp_pkg::ADDR_W-1:0]       i_instr_ptr,
    input  logic                              i_is_prefetch_fill,
    input  logic [icsp_pkg::META_W-1:0]       i_meta_in,

    // Result words.
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_pf_valid,
    output logic [icsp_pkg::ADDR_W-1:0]       o_pf_addr,
    output logic [icsp_pkg::META_W-1:0]       o_meta_out,
    output logic                              o_last,

    // Configuration writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [icsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [icsp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers. The port never stalls; writes to indexes beyond
    // the register list are accepted and ignored.
    logic [icsp_pkg::DEG_W-1:0] r_degree;
    logic                       r_single;
    icsp_pkg::t_cfg             cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            r_single <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                icsp_pkg::CFG_DEGREE: r_degree <= i_cfg_data[icsp_pkg::DEG_W-1:0];
                icsp_pkg::CFG_SINGLE: r_single <= i_cfg_data[0];
                default: begin
                    r_degree <= r_degree;
                end
            endcase
        end
    end

    assign cfg.degree      = r_degree;
    assign cfg.single_core = r_single;

    // The front end decodes each access and buffers it; the back end pulls one
    // access at a time, reads its table entry, writes the update in the next
    // cycle, and then streams out the result words through its output register.
    logic              head_valid;
    icsp_pkg::t_item   head;
    logic              head_pop;
    logic              clearing;
    logic              res_valid;
    icsp_pkg::t_result res;

    icsp_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_access_addr      (i_access_addr),
        .i_instr_ptr        (i_instr_ptr),
        .i_is_prefetch_fill (i_is_prefetch_fill),
        .i_meta_in          (i_meta_in),
        .i_hold             (clearing),
        .o_head_valid       (head_valid),
        .o_head             (head),
        .i_head_pop         (head_pop)
    );

    icsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (head_valid),
        .i_item       (head),
        .o_item_pop   (head_pop),
        .o_clearing   (clearing),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_pop    (pop)
    );

    // The oldest result word sits in the back end's output register.
    assign empty      = !res_valid;
    assign o_pf_valid = res.pf_valid;
    assign o_pf_addr  = res.pf_addr;
    assign o_meta_out = res.meta_out;
    assign o_last     = res.last;

endmodule

/* sim/testbench.sv */
// Self-checking bench for ip_class_stride_prefetcher: directed and random cache accesses.
// Depends on icsp_pkg for widths, class codes and register indexes, and on the design sources.
`timescale 1ns / 1ps

import icsp_pkg::*;

// Tracks the prefetch table and the configuration registers, and holds the result words
// that each accepted access still owes, oldest first.
class prefetch_ledger;
    logic [TAG_BITS-1:0] tag_tbl    [TABLE_DEPTH];
    logic                valid_tbl  [TABLE_DEPTH];
    logic [CLASS_W-1:0]  class_tbl  [TABLE_DEPTH];
    logic [STRIDE_W-1:0] stride_tbl [TABLE_DEPTH];
    logic                spec_nl;
    logic [DEG_W-1:0]    degree;
    logic                single_core;
    t_result             owed [$];
    int                  mismatches;

    function new();
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            tag_tbl[k]    = '0;
            valid_tbl[k]  = 1'b0;
            class_tbl[k]  = '0;
            stride_tbl[k] = '0;
        end
        spec_nl     = 1'b0;
        degree      = '0;
        single_core = 1'b1;
        mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_DEGREE) begin
            degree = data;
        end else if (idx == CFG_SINGLE) begin
            single_core = data[0];
        end
    endfunction

    // Updates the table for one accepted access and queues the words it must produce.
    function void note_access(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] ip, logic fill,
                              logic [META_W-1:0] meta);
        logic [ADDR_W-1:0]     blk;
        logic [ADDR_W-1:0]     nxt;
        logic [ADDR_W-1:0]     step;
        logic [ADDR_W-1:0]     pfa;
        logic [INDEX_BITS-1:0] idx;
        logic [TAG_BITS-1:0]   tg;
        logic [STRIDE_W-1:0]   fresh_stride;
        logic [STRIDE_W-1:0]   str;
        logic [CLASS_W-1:0]    cls;
        logic [DEG_W-1:0]      deg;
        logic                  crossed;
        logic [ADDR_W-1:0]     pf_list [$];
        t_result               w;
        int                    i;

        blk = addr >> BLOCK_SHIFT;
        nxt = (blk + 64'd1) << BLOCK_SHIFT;
        idx = ip[INDEX_BITS-1:0];
        tg  = ip[INDEX_BITS +: TAG_BITS];
        // Sign-magnitude to two's complement; a negative zero comes out as zero.
        fresh_stride = meta[META_SIGN_BIT] ? (7'd0 - {1'b0, meta[5:0]}) : {1'b0, meta[5:0]};

        if (tag_tbl[idx] != tg) begin
            if (!valid_tbl[idx]) begin
                tag_tbl[idx]    = tg;
                class_tbl[idx]  = meta[META_CLASS_LSB +: CLASS_W];
                stride_tbl[idx] = fresh_stride;
            end else begin
                valid_tbl[idx] = 1'b0;
            end
            pf_list.push_back(nxt);
        end else begin
            valid_tbl[idx] = 1'b1;
            if (fill) begin
                class_tbl[idx]  = meta[META_CLASS_LSB +: CLASS_W];
                stride_tbl[idx] = fresh_stride;
                spec_nl         = meta[META_SPEC_BIT];
            end
            str = stride_tbl[idx];
            cls = class_tbl[idx];
            if (str != '0) begin
                if (cls == CLS_GS || cls == CLS_CS) begin
                    deg = (degree > MAX_DEGREE) ? MAX_DEGREE : degree;
                    if (cls == CLS_GS && single_core) begin
                        deg = GS_DEGREE;
                    end
                    crossed = 1'b0;
                    for (i = 1; i <= int'(deg) && !crossed; i++) begin
                        step = {{(ADDR_W-STRIDE_W){str[STRIDE_W-1]}}, str} * 64'(i);
                        pfa  = (blk + step) << BLOCK_SHIFT;
                        if ((pfa >> PAGE_SHIFT) != (addr >> PAGE_SHIFT)) begin
                            crossed = 1'b1;
                        end else begin
                            pf_list.push_back(pfa);
                        end
                    end
                end else if (cls == CLS_NL && spec_nl) begin
                    pf_list.push_back(nxt);
                end
            end
        end

        w.meta_out = meta;
        if (pf_list.size() == 0) begin
            w.pf_valid = 1'b0;
            w.pf_addr  = '0;
            w.last     = 1'b1;
            owed.push_back(w);
        end else begin
            foreach (pf_list[k]) begin
                w.pf_valid = 1'b1;
                w.pf_addr  = pf_list[k];
                w.last     = (k == pf_list.size() - 1);
                owed.push_back(w);
            end
        end
    endfunction

    function void note_failure(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function void check_word(logic v, logic [ADDR_W-1:0] a, logic [META_W-1:0] m, logic l);
        t_result w;
        if (owed.size() == 0) begin
            note_failure($sformatf("unexpected word valid=%0b addr=%h meta=%h last=%0b",
                                   v, a, m, l));
            return;
        end
        w = owed.pop_front();
        if (v !== w.pf_valid || a !== w.pf_addr || m !== w.meta_out || l !== w.last) begin
            note_failure($sformatf(
                "expected valid=%0b addr=%h meta=%h last=%0b, got valid=%0b addr=%h meta=%h last=%0b",
                w.pf_valid, w.pf_addr, w.meta_out, w.last, v, a, m, l));
        end
    endfunction

    function int owed_count();
        return owed.size();
    endfunction

    // Words still owed at the end of the run are failures too.
    function void close();
        if (owed.size() != 0) begin
            note_failure($sformatf("%0d words never arrived", owed.size()));
        end
    endfunction
endclass

module testbench;

    // Registers 2 and 3 do not exist; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;
    // A class code that the block does not know.
    localparam logic [CLASS_W-1:0]   CLS_ODD    = 4'd3;

    localparam int STREAMS     = 6;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;
    // Longest legal quiet stretch is the table clear after reset or the long receiver
    // hold-off; this limit covers either several times over.
    localparam int STALL_LIMIT = 5000;

    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  push               = 1'b0;
    logic                  full;
    logic [ADDR_W-1:0]     i_access_addr      = '0;
    logic [ADDR_W-1:0]     i_instr_ptr        = '0;
    logic                  i_is_prefetch_fill = 1'b0;
    logic [META_W-1:0]     i_meta_in          = '0;
    logic                  empty;
    logic                  pop                = 1'b0;
    logic                  o_pf_valid;
    logic [ADDR_W-1:0]     o_pf_addr;
    logic [META_W-1:0]     o_meta_out;
    logic                  o_last;
    logic                  i_cfg_valid        = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data         = '0;

    prefetch_ledger ledger;

    // Receiver state: a stall pattern that rotates every cycle outside the hold-off and is
    // reloaded now and then, plus a long hold-off that the stimulus requests by bumping hold_token.
    int          hold_token  = 0;
    int          hold_seen   = 0;
    int          hold_cnt    = 0;
    int          pat_age     = 0;
    logic [15:0] pop_pat     = 16'hB5D3;
    int          idle_cycles = 0;

    // Access streams: each one reuses its instruction pointer so that the table entry
    // trains up and then hits, with addresses marching along.
    logic [ADDR_W-1:0] st_ip   [STREAMS];
    logic [ADDR_W-1:0] st_addr [STREAMS];
    logic [META_W-1:0] st_meta [STREAMS];

    ip_class_stride_prefetcher dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_access_addr      (i_access_addr),
        .i_instr_ptr        (i_instr_ptr),
        .i_is_prefetch_fill (i_is_prefetch_fill),
        .i_meta_in          (i_meta_in),
        .empty              (empty),
        .pop                (pop),
        .o_pf_valid         (o_pf_valid),
        .o_pf_addr          (o_pf_addr),
        .o_meta_out         (o_meta_out),
        .o_last             (o_last),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Result side. Words are checked at the edge where they are popped; pop for the
    // next cycle follows either the hold-off counter or the rotating pattern.
    always @(posedge i_clk) begin
        if (pop && !empty) begin
            ledger.check_word(o_pf_valid, o_pf_addr, o_meta_out, o_last);
        end
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_cnt  = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
        end else begin
            pat_age++;
            if (pat_age == 96) begin
                pat_age = 0;
                // A quarter of the time the receiver never stalls for a while.
                pop_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
            end
            pop_pat = {pop_pat[0], pop_pat[15:1]};
            pop <= pop_pat[0];
        end
    end

    // Watchdog: counts cycles in which no word moves on any channel.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [META_W-1:0] mk_meta(logic [CLASS_W-1:0] cls, logic neg,
                                                  logic [5:0] mag, logic spec);
        return {spec, cls, 1'b0, neg, mag};
    endfunction

    // Mostly the three known classes with short strides, sometimes anything at all.
    function automatic logic [META_W-1:0] random_meta();
        logic [CLASS_W-1:0] cls;
        logic [5:0]         mag;
        int                 pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            cls = CLS_GS;
        end else if (pick < 6) begin
            cls = CLS_CS;
        end else if (pick < 8) begin
            cls = CLS_NL;
        end else begin
            cls = 4'($urandom);
        end
        mag = ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(1, 6));
        return mk_meta(cls, 1'($urandom), mag, 1'($urandom)) | (13'($urandom_range(0, 1)) << 7);
    endfunction

    // Offers one access word and returns at the edge where it is taken. Push stays high
    // so that the next word can follow without a bubble.
    task automatic offer_access(input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] ip,
                                input logic fill, input logic [META_W-1:0] meta);
        push               <= 1'b1;
        i_access_addr      <= addr;
        i_instr_ptr        <= ip;
        i_is_prefetch_fill <= fill;
        i_meta_in          <= meta;
        do @(posedge i_clk); while (full);
        ledger.note_access(addr, ip, fill, meta);
    endtask

    task automatic pause_push(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stops offering and waits until every owed word has been popped, then lets the
    // pipeline settle so the block is idle before any register write.
    task automatic drain_results();
        push <= 1'b0;
        while (ledger.owed_count() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.write_reg(idx, data);
    endtask

    // Writes both registers back to back, then the two unused indexes with junk.
    // The spare data bits of single_core are random; only bit 0 counts.
    task automatic write_regs(input logic [DEG_W-1:0] deg, input logic sc);
        cfg_word(CFG_DEGREE, deg);
        cfg_word(CFG_SINGLE, {4'($urandom), sc});
        cfg_word(CFG_SPARE2, 5'($urandom));
        cfg_word(CFG_SPARE3, 5'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic new_streams();
        for (int s = 0; s < STREAMS; s++) begin
            st_ip[s]   = {$urandom, $urandom};
            // Some streams share a table index with the previous one under another tag,
            // so they keep knocking each other's valid bit down.
            if (s > 0 && $urandom_range(0, 3) == 0) begin
                st_ip[s][INDEX_BITS-1:0] = st_ip[s-1][INDEX_BITS-1:0];
            end
            st_addr[s] = {$urandom, $urandom};
            st_meta[s] = random_meta();
        end
    endtask

    // Seven in ten accesses continue a stream; the rest are fully random noise.
    task automatic random_access();
        int s;
        if ($urandom_range(0, 9) < 7) begin
            s = $urandom_range(0, STREAMS - 1);
            if ($urandom_range(0, 7) == 0) begin
                st_meta[s] = random_meta();
            end
            if ($urandom_range(0, 3) == 0) begin
                st_addr[s] = st_addr[s] + 64'($urandom_range(0, 255));
            end else begin
                st_addr[s] = st_addr[s] + (64'($urandom_range(0, 4)) << BLOCK_SHIFT);
            end
            offer_access(st_addr[s], st_ip[s], 1'($urandom), st_meta[s]);
        end else begin
            offer_access({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom),
                         13'($urandom));
        end
    endtask

    initial begin
        logic [DEG_W-1:0] ph_deg [6];
        logic             ph_sc  [6];
        int               burst;

        ledger = new();
        ph_deg = '{5'd4, 5'd16, 5'd0, 5'd31, 5'd1, 5'($urandom)};
        ph_sc  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom)};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The block clears its table after reset with full high, so the
        // first access waits that out. Full degree, multi-core behavior first.
        write_regs(5'd16, 1'b0);
        // Instruction pointer zero hits the cleared entry at once: stride zero, nothing to fetch.
        offer_access(64'h0, 64'h0, 1'b0, 13'h0);
        // Constant stride +1 from a fill: sixteen prefetches in the page.
        offer_access(64'h40, 64'h0, 1'b1, mk_meta(CLS_CS, 1'b0, 6'd1, 1'b0));
        // Global stream +3 with single core off: the full degree applies.
        offer_access(64'h100, 64'h0, 1'b1, mk_meta(CLS_GS, 1'b0, 6'd3, 1'b0));
        // Negative stride that runs off the bottom of its page after twelve steps.
        offer_access(64'h1F00, 64'h0, 1'b1, mk_meta(CLS_CS, 1'b1, 6'd5, 1'b0));
        // First step already crosses the page, so no prefetch at all.
        offer_access(64'h1FC0, 64'h0, 1'b1, mk_meta(CLS_CS, 1'b0, 6'd1, 1'b0));
        // Sign bit with zero magnitude is a zero stride.
        offer_access(64'h200, 64'h0, 1'b1, mk_meta(CLS_CS, 1'b1, 6'd0, 1'b0));
        // Unknown classes, including the widest metadata below the speculative flag.
        offer_access(64'h300, 64'h0, 1'b1, mk_meta(CLS_ODD, 1'b0, 6'd2, 1'b0));
        offer_access(64'h340, 64'h0, 1'b1, 13'h0FFF);
        // Next-line class with and without the speculative flag.
        offer_access(64'h400, 64'h0, 1'b1, mk_meta(CLS_NL, 1'b0, 6'd1, 1'b1));
        offer_access(64'h400, 64'h0, 1'b1, mk_meta(CLS_NL, 1'b0, 6'd1, 1'b0));
        // Top block of the address space: a positive step wraps to page zero and stops,
        // a negative one walks down within the last page.
        offer_access(64'hFFFF_FFFF_FFFF_FFC0, 64'h0, 1'b1, mk_meta(CLS_CS, 1'b0, 6'd1, 1'b0));
        offer_access(64'hFFFF_FFFF_FFFF_FFC0, 64'h0, 1'b1, mk_meta(CLS_GS, 1'b1, 6'd1, 1'b0));
        // All metadata bits set.
        offer_access(64'h500, 64'h0, 1'b1, 13'h1FFF);
        // Another tag on index zero: the first miss clears the valid bit (next line wraps
        // to zero), the second takes the entry over, the third hits it.
        offer_access(64'hFFFF_FFFF_FFFF_FFC0, 64'h400, 1'b0, 13'h0);
        offer_access(64'h800, 64'h400, 1'b1, mk_meta(CLS_CS, 1'b0, 6'd7, 1'b0));
        offer_access(64'h800, 64'h400, 1'b0, 13'h0);
        // All-ones address and instruction pointer: miss with wrap, then a hit on an
        // entry of unknown class.
        offer_access({ADDR_W{1'b1}}, {ADDR_W{1'b1}}, 1'b1, 13'h1FFF);
        offer_access({ADDR_W{1'b1}}, {ADDR_W{1'b1}}, 1'b0, 13'h0);

        // Degree register above sixteen saturates; single core pins global stream to four.
        drain_results();
        write_regs(5'd31, 1'b1);
        offer_access(64'h0, 64'h5, 1'b1, mk_meta(CLS_CS, 1'b0, 6'd1, 1'b0));
        offer_access(64'h0, 64'h5, 1'b1, mk_meta(CLS_GS, 1'b0, 6'd1, 1'b0));
        drain_results();
        write_regs(5'd0, 1'b0);
        offer_access(64'h0, 64'h5, 1'b1, mk_meta(CLS_CS, 1'b0, 6'd1, 1'b0));
        offer_access(64'h0, 64'h5, 1'b1, mk_meta(CLS_GS, 1'b0, 6'd1, 1'b0));

        // Random part: six register settings, thirty accesses each, sent in bursts but for the hold-off phase.
        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            write_regs(ph_deg[ph], ph_sc[ph]);
            new_streams();
            if (ph == 1) begin
                // Receiver holds off for a long stretch while accesses keep coming
                // back to back, so the block backs up and raises full.
                hold_token <= hold_token + 1;
                repeat (30) random_access();
            end else begin
                burst = $urandom_range(1, 12);
                for (int n = 0; n < 30; n++) begin
                    random_access();
                    if (ph == 3 && n == 15) begin
                        drain_results();
                    end
                    burst--;
                    if (burst == 0) begin
                        pause_push($urandom_range(1, 8));
                        burst = $urandom_range(1, 12);
                    end
                end
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        ledger.close();
        if (ledger.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
design/icsp_pkg.sv
design/icsp_ram.sv
design/icsp_front.sv
design/icsp_back.sv
design/ip_class_stride_prefetcher.sv
sim/testbench.sv
